[design/qvr_pkg.sv]
`default_nettype none

package qvr_pkg;

   // Register stages from input beat to result beat
   localparam int STAGES = 4;

   // Component positions within the quaternion and vector arrays
   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2,
      AXIS_W = 2'd3
   } axis_type;

endpackage

`default_nettype wire

[design/qvr_round_sat.sv]
`default_nettype none

module qvr_round_sat #(
   parameter int ACC_W = 35,
   parameter int OUT_W = 16,
   parameter int FRAC  = 14
) (
   input  wire logic signed [ACC_W-1:0] acc,
   output logic signed [OUT_W-1:0]      res,
   output logic                         clip
);

   localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC - 1);
   localparam logic [OUT_W-1:0] MAX_VAL = {1'b0, {(OUT_W-1){1'b1}}};
   localparam logic [OUT_W-1:0] MIN_VAL = {1'b1, {(OUT_W-1){1'b0}}};

   logic signed [ACC_W-1:0] biased;
   logic signed [ACC_W-1:0] shifted;
   logic [ACC_W-OUT_W:0]    upper;

   // round half up, then clip to OUT_W bits
   always_comb begin
      biased  = acc + HALF;
      shifted = biased >>> FRAC;
      upper   = shifted[ACC_W-1:OUT_W-1];
      clip    = !((&upper) || !(|upper));
      if (clip) begin
         res = shifted[ACC_W-1] ? MIN_VAL : MAX_VAL;
      end else begin
         res = shifted[OUT_W-1:0];
      end
   end

endmodule

`default_nettype wire

[design/quaternion_vector_rotate.sv]
// Rotates a vector by a unit quaternion as the xyz part of conj(q) * (v,0) * q.
// Quaternion parts are signed Q1.FRAC_BITS, vector and result parts signed
// DATA_WIDTH-bit integers. One beat is taken every cycle while no stall holds the
// pipeline, and each result passes through the four register stages: first
// products, rounded intermediate quaternion, second products, rounded output.
// req_tready follows rsp_tready through the pipeline and stays high while any
// stage is empty, so bubbles close up on a stall. The intermediate product is
// clipped to DATA_WIDTH+2 bits and the result to DATA_WIDTH bits; any clipping
// sets the saturated bit of that result. The quaternion is not normalized.
`default_nettype none

module quaternion_vector_rotate #(
   parameter int FRAC_BITS  = 14,
   parameter int DATA_WIDTH = 16
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z, zero pad
   input  wire logic [((7*DATA_WIDTH+7)/8)*8-1:0]     req_tdata,

   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // rot_x, rot_y, rot_z, saturated, zero pad
   output logic [((3*DATA_WIDTH+1+7)/8)*8-1:0]        rsp_tdata
);

   localparam int W       = DATA_WIDTH;
   localparam int STAGES  = qvr_pkg::STAGES;
   localparam int PROD1_W = 2 * W;
   localparam int ACC1_W  = (2 * W + 3 > FRAC_BITS + 2) ? 2 * W + 3 : FRAC_BITS + 2;
   localparam int P_W     = W + 2;
   localparam int PROD2_W = P_W + W;
   localparam int ACC2_W  = (2 * W + 5 > FRAC_BITS + 2) ? 2 * W + 5 : FRAC_BITS + 2;
   localparam int RSP_DW  = ((3 * W + 1 + 7) / 8) * 8;

   // handshake chain
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] stage_ready;
   logic [STAGES-1:0] load;

   always_comb begin
      stage_ready[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_ready[k] = !valid_ff[k] || stage_ready[k+1];
      end
      load[0]     = stage_ready[0] && req_tvalid;
      valid_in[0] = stage_ready[0] ? req_tvalid : valid_ff[0];
      for (int k = 1; k < STAGES; k++) begin
         load[k]     = stage_ready[k] && valid_ff[k-1];
         valid_in[k] = stage_ready[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ready[0];
   assign rsp_tvalid = valid_ff[STAGES-1];

   // stage 1: products of quaternion and vector
   logic signed [W-1:0]       q_in  [4];
   logic signed [W-1:0]       v_in  [3];
   logic signed [PROD1_W-1:0] m1_in [12];
   logic signed [PROD1_W-1:0] m1_ff [12];
   logic signed [W-1:0]       q1_ff [4];

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         q_in[i] = $signed(req_tdata[i*W +: W]);
      end
      for (int i = 0; i < 3; i++) begin
         v_in[i] = $signed(req_tdata[(4+i)*W +: W]);
      end
      // px = qw*vx + qz*vy - qy*vz
      m1_in[0]  = q_in[qvr_pkg::AXIS_W] * v_in[qvr_pkg::AXIS_X];
      m1_in[1]  = q_in[qvr_pkg::AXIS_Z] * v_in[qvr_pkg::AXIS_Y];
      m1_in[2]  = q_in[qvr_pkg::AXIS_Y] * v_in[qvr_pkg::AXIS_Z];
      // py = qw*vy + qx*vz - qz*vx
      m1_in[3]  = q_in[qvr_pkg::AXIS_W] * v_in[qvr_pkg::AXIS_Y];
      m1_in[4]  = q_in[qvr_pkg::AXIS_X] * v_in[qvr_pkg::AXIS_Z];
      m1_in[5]  = q_in[qvr_pkg::AXIS_Z] * v_in[qvr_pkg::AXIS_X];
      // pz = qw*vz + qy*vx - qx*vy
      m1_in[6]  = q_in[qvr_pkg::AXIS_W] * v_in[qvr_pkg::AXIS_Z];
      m1_in[7]  = q_in[qvr_pkg::AXIS_Y] * v_in[qvr_pkg::AXIS_X];
      m1_in[8]  = q_in[qvr_pkg::AXIS_X] * v_in[qvr_pkg::AXIS_Y];
      // pw = qx*vx + qy*vy + qz*vz
      m1_in[9]  = q_in[qvr_pkg::AXIS_X] * v_in[qvr_pkg::AXIS_X];
      m1_in[10] = q_in[qvr_pkg::AXIS_Y] * v_in[qvr_pkg::AXIS_Y];
      m1_in[11] = q_in[qvr_pkg::AXIS_Z] * v_in[qvr_pkg::AXIS_Z];
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         m1_ff <= m1_in;
         q1_ff <= q_in;
      end
   end

   // stage 2: intermediate quaternion p, rounded and clipped
   logic signed [ACC1_W-1:0] acc1 [4];
   logic signed [P_W-1:0]    p_in [4];
   logic [3:0]               clip1;
   logic signed [P_W-1:0]    p_ff [4];
   logic signed [W-1:0]      q2_ff [4];
   logic                     clip2_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc1[i] = ACC1_W'(m1_ff[3*i]) + ACC1_W'(m1_ff[3*i+1]) - ACC1_W'(m1_ff[3*i+2]);
      end
      acc1[3] = ACC1_W'(m1_ff[9]) + ACC1_W'(m1_ff[10]) + ACC1_W'(m1_ff[11]);
   end

   for (genvar g = 0; g < 4; g++) begin : g_round1
      qvr_round_sat #(
         .ACC_W (ACC1_W),
         .OUT_W (P_W),
         .FRAC  (FRAC_BITS)
      ) u_round (
         .acc  (acc1[g]),
         .res  (p_in[g]),
         .clip (clip1[g])
      );
   end

   always_ff @(posedge clock) begin
      if (load[1]) begin
         p_ff     <= p_in;
         q2_ff    <= q1_ff;
         clip2_ff <= |clip1;
      end
   end

   // stage 3: products of p and q
   logic signed [PROD2_W-1:0] m3_in [12];
   logic signed [PROD2_W-1:0] m3_ff [12];
   logic                      clip3_ff;

   always_comb begin
      // rx = px*qw + py*qz + pw*qx - pz*qy
      m3_in[0]  = p_ff[qvr_pkg::AXIS_X] * q2_ff[qvr_pkg::AXIS_W];
      m3_in[1]  = p_ff[qvr_pkg::AXIS_Y] * q2_ff[qvr_pkg::AXIS_Z];
      m3_in[2]  = p_ff[qvr_pkg::AXIS_W] * q2_ff[qvr_pkg::AXIS_X];
      m3_in[3]  = p_ff[qvr_pkg::AXIS_Z] * q2_ff[qvr_pkg::AXIS_Y];
      // ry = py*qw + pz*qx + pw*qy - px*qz
      m3_in[4]  = p_ff[qvr_pkg::AXIS_Y] * q2_ff[qvr_pkg::AXIS_W];
      m3_in[5]  = p_ff[qvr_pkg::AXIS_Z] * q2_ff[qvr_pkg::AXIS_X];
      m3_in[6]  = p_ff[qvr_pkg::AXIS_W] * q2_ff[qvr_pkg::AXIS_Y];
      m3_in[7]  = p_ff[qvr_pkg::AXIS_X] * q2_ff[qvr_pkg::AXIS_Z];
      // rz = pz*qw + pw*qz + px*qy - py*qx
      m3_in[8]  = p_ff[qvr_pkg::AXIS_Z] * q2_ff[qvr_pkg::AXIS_W];
      m3_in[9]  = p_ff[qvr_pkg::AXIS_W] * q2_ff[qvr_pkg::AXIS_Z];
      m3_in[10] = p_ff[qvr_pkg::AXIS_X] * q2_ff[qvr_pkg::AXIS_Y];
      m3_in[11] = p_ff[qvr_pkg::AXIS_Y] * q2_ff[qvr_pkg::AXIS_X];
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         m3_ff    <= m3_in;
         clip3_ff <= clip2_ff;
      end
   end

   // stage 4: result, rounded and clipped
   logic signed [ACC2_W-1:0] acc2   [3];
   logic signed [W-1:0]      rot_in [3];
   logic [2:0]               clip2;
   logic signed [W-1:0]      rot_ff [3];
   logic                     sat_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         acc2[i] = ACC2_W'(m3_ff[4*i]) + ACC2_W'(m3_ff[4*i+1])
                 + ACC2_W'(m3_ff[4*i+2]) - ACC2_W'(m3_ff[4*i+3]);
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_round2
      qvr_round_sat #(
         .ACC_W (ACC2_W),
         .OUT_W (W),
         .FRAC  (FRAC_BITS)
      ) u_round (
         .acc  (acc2[g]),
         .res  (rot_in[g]),
         .clip (clip2[g])
      );
   end

   always_ff @(posedge clock) begin
      if (load[3]) begin
         rot_ff <= rot_in;
         sat_ff <= clip3_ff || (|clip2);
      end
   end

   assign rsp_tdata = RSP_DW'({sat_ff, rot_ff[2], rot_ff[1], rot_ff[0]});

endmodule

`default_nettype wire

[design/qvr_check.sv]
`default_nettype none

module qvr_check #(
   parameter int RSP_DW = 56
) (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_tvalid,
   input wire logic              req_tready,
   input wire logic              rsp_tvalid,
   input wire logic              rsp_tready,
   input wire logic [RSP_DW-1:0] rsp_tdata
);

   localparam int CNT_W = $clog2(qvr_pkg::STAGES + 1);

   logic [CNT_W-1:0] pending_ff;
   logic [CNT_W-1:0] pending_in;

   // beats accepted and not yet delivered
   assign pending_in = pending_ff + CNT_W'(req_tvalid && req_tready)
                     - CNT_W'(rsp_tvalid && rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pending_ff != '0)
      else $error("result beat without a pending input beat");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(qvr_pkg::STAGES))
      else $error("more beats in flight than pipeline stages");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled while output stage is empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

endmodule

bind quaternion_vector_rotate qvr_check #(
   .RSP_DW ($bits(rsp_tdata))
) u_qvr_check (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/sv/tb_quaternion_vector_rotate.sv]
`default_nettype none

module tb_quaternion_vector_rotate;

   localparam int FB = 14;
   localparam int DW = 16;

   // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z (lowest first)
   typedef struct packed {
      logic signed [DW-1:0] vec_z;
      logic signed [DW-1:0] vec_y;
      logic signed [DW-1:0] vec_x;
      logic signed [DW-1:0] quat_w;
      logic signed [DW-1:0] quat_z;
      logic signed [DW-1:0] quat_y;
      logic signed [DW-1:0] quat_x;
   } rot_req_type;

   // rot_x, rot_y, rot_z, saturated, pad (lowest first)
   typedef struct packed {
      logic [6:0]           pad;
      logic                 saturated;
      logic signed [DW-1:0] rot_z;
      logic signed [DW-1:0] rot_y;
      logic signed [DW-1:0] rot_x;
   } rot_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_tvalid = 1'b0;
   wire logic   req_tready;
   rot_req_type req_tdata = '0;   // quat_x, quat_y, quat_z, quat_w, vec_x, vec_y, vec_z
   wire logic   rsp_tvalid;
   logic        rsp_tready = 1'b0;
   rot_rsp_type rsp_tdata;        // rot_x, rot_y, rot_z, saturated

   rot_req_type beat_q[$];
   rot_rsp_type rot_expect_q[$];
   bit       calm = 1'b0;
   int       fail_cnt = 0;
   int       rot_beats = 0;
   int       hold_left = 0;
   bit       held = 1'b0;

   quaternion_vector_rotate #(.FRAC_BITS(FB), .DATA_WIDTH(DW)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #1 clock = ~clock;

   // round half up by FB bits, clip to width bits signed
   function automatic longint scale_sat(input longint acc, input int width, inout bit clip);
      longint t;
      longint top;
      t = (acc + (longint'(1) <<< (FB - 1))) >>> FB;
      top = (longint'(1) <<< (width - 1)) - 1;
      if (t > top) begin
         clip = 1'b1;
         t = top;
      end else if (t < -top - 1) begin
         clip = 1'b1;
         t = -top - 1;
      end
      return t;
   endfunction

   // xyz of conj(q) * (v,0) * q
   function automatic rot_rsp_type rotate_vector(input rot_req_type b);
      longint qx, qy, qz, qw, vx, vy, vz;
      longint px, py, pz, pw;
      bit clip;
      rot_rsp_type r;
      qx = longint'($signed(b.quat_x));
      qy = longint'($signed(b.quat_y));
      qz = longint'($signed(b.quat_z));
      qw = longint'($signed(b.quat_w));
      vx = longint'($signed(b.vec_x));
      vy = longint'($signed(b.vec_y));
      vz = longint'($signed(b.vec_z));
      clip = 1'b0;
      px = scale_sat(qz * vy - qy * vz + qw * vx, DW + 2, clip);
      py = scale_sat(qx * vz - qz * vx + qw * vy, DW + 2, clip);
      pz = scale_sat(qy * vx - qx * vy + qw * vz, DW + 2, clip);
      pw = scale_sat(qx * vx + qy * vy + qz * vz, DW + 2, clip);
      r = '0;
      r.rot_x = DW'(scale_sat(px * qw + py * qz - pz * qy + pw * qx, DW, clip));
      r.rot_y = DW'(scale_sat(py * qw - px * qz + pz * qx + pw * qy, DW, clip));
      r.rot_z = DW'(scale_sat(px * qy - py * qx + pz * qw + pw * qz, DW, clip));
      r.saturated = clip;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            rot_expect_q.push_back(rotate_vector(req_tdata));
         if (!req_tvalid || req_tready) begin
            if (beat_q.size() != 0 && (calm || $urandom_range(99) >= 12)) begin
               req_tdata  <= beat_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rot_rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            rot_beats++;
            if (rot_expect_q.size() == 0) begin
               $display("%0t: unexpected result beat %h", $time, rsp_tdata);
               fail_cnt++;
            end else begin
               want = rot_expect_q.pop_front();
               if (rsp_tdata.rot_x !== want.rot_x || rsp_tdata.rot_y !== want.rot_y ||
                   rsp_tdata.rot_z !== want.rot_z ||
                   rsp_tdata.saturated !== want.saturated) begin
                  $display({"%0t: expected x=%0d y=%0d z=%0d sat=%0b,",
                            " got x=%0d y=%0d z=%0d sat=%0b"},
                           $time, want.rot_x, want.rot_y, want.rot_z, want.saturated,
                           rsp_tdata.rot_x, rsp_tdata.rot_y, rsp_tdata.rot_z,
                           rsp_tdata.saturated);
                  fail_cnt++;
               end
            end
         end
         if (!held && rot_beats >= 200) begin
            held = 1'b1;
            hold_left = 300;
         end
         if (hold_left != 0)
            hold_left--;
         rsp_tready <= (hold_left == 0) && (calm || $urandom_range(99) >= 12);
      end
   end

   task automatic push_beat(input int qx, qy, qz, qw, vx, vy, vz);
      rot_req_type b;
      b.quat_x = DW'(qx);
      b.quat_y = DW'(qy);
      b.quat_z = DW'(qz);
      b.quat_w = DW'(qw);
      b.vec_x  = DW'(vx);
      b.vec_y  = DW'(vy);
      b.vec_z  = DW'(vz);
      beat_q.push_back(b);
   endtask

   function automatic int pick_edge();
      case ($urandom_range(5))
         0: return -32768;
         1: return -1;
         2: return 0;
         3: return 1;
         4: return 32767;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   task automatic push_random();
      int a[4];
      int v[3];
      int k;
      real n;
      real s;
      k = $urandom_range(99);
      for (int i = 0; i < 3; i++)
         v[i] = (k >= 55 && k < 70) ? int'($urandom_range(510)) - 255
                                    : int'($urandom_range(65535)) - 32768;
      if (k < 70) begin
         // unit quaternion
         for (int i = 0; i < 4; i++)
            a[i] = int'($urandom_range(32768)) - 16384;
         n = $sqrt(real'(a[0]) * a[0] + real'(a[1]) * a[1] +
                   real'(a[2]) * a[2] + real'(a[3]) * a[3]);
         if (n < 1.0) begin
            a = '{0, 0, 0, 16384};
         end else begin
            s = 16384.0 / n;
            for (int i = 0; i < 4; i++)
               a[i] = $rtoi(a[i] * s);
         end
      end else if (k < 85) begin
         for (int i = 0; i < 4; i++)
            a[i] = int'($urandom_range(65535)) - 32768;
      end else begin
         for (int i = 0; i < 4; i++)
            a[i] = pick_edge();
         for (int i = 0; i < 3; i++)
            v[i] = pick_edge();
      end
      push_beat(a[0], a[1], a[2], a[3], v[0], v[1], v[2]);
   endtask

   task automatic drain();
      while (beat_q.size() != 0 || req_tvalid || rot_expect_q.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_beat(0, 0, 0, 0, 0, 0, 0);
      push_beat(0, 0, 0, 16384, 32767, -32768, 1);
      push_beat(0, 0, 0, 16384, -32768, -32768, -32768);
      push_beat(0, 0, 11585, 11585, 1000, 0, 0);
      push_beat(11585, 0, 0, 11585, 0, 1000, -2000);
      push_beat(0, 11585, 0, 11585, 300, -400, 500);
      push_beat(16384, 0, 0, 0, 32767, 32767, -32768);
      push_beat(-16384, 0, 0, 0, -32768, 32767, 12345);
      push_beat(-32768, -32768, -32768, -32768, -32768, -32768, -32768);
      push_beat(32767, 32767, 32767, 32767, 32767, 32767, 32767);
      // intermediate part leaves 18 bits
      push_beat(-32768, 32767, -32768, 32767, 32767, -32768, -32768);
      // intermediate fits, final clips
      push_beat(0, 0, 0, -32768, -32768, 5, -5);
      // half-way rounding
      push_beat(0, 0, 0, 8192, 1, -1, 3);
      push_beat(1, 1, 1, 1, -1, -1, -1);
      push_beat(21845, -21846, 21845, -21846, -21846, 21845, -21846);
      push_beat(0, 0, 6270, 15137, 10000, 20000, -30000);
      push_beat(-6270, 0, 0, -15137, -32768, 32767, 0);
      drain();

      repeat (500) push_random();
      drain();

      calm = 1'b1;
      repeat (300) push_random();
      drain();

      calm = 1'b0;
      repeat (733) push_random();
      drain();

      repeat (4 * qvr_pkg::STAGES) @(negedge clock);
      if (fail_cnt == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

`default_nettype wire
